FILE: design/csk_pkg.sv
// Shared types and constants for the color switch block.
`timescale 1ns / 1ps

package csk_pkg;

  localparam int NumEntriesDef = 8;

  localparam int RgbW     = 24;
  localparam int AlphaW   = 8;
  localparam int IdxW     = 3;
  localparam int ModeW    = 2;
  localparam int CountW   = 4;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 4;

  localparam logic [ModeW-1:0] MODE_REPLACE = 2'd0;
  localparam logic [ModeW-1:0] MODE_KEY     = 2'd1;
  localparam logic [ModeW-1:0] MODE_EXTRACT = 2'd2;
  localparam logic [ModeW-1:0] MODE_PASS    = 2'd3;

  localparam logic [CfgIdxW-1:0] CFG_ENABLE_ALL   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SWITCH_MODE  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ACTIVE_COUNT = 2'd2;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // One table entry update as it is passed to the match table.
  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] idx;
    logic            ena;
    logic [RgbW-1:0] rgb;
  } tbl_wr_t;

endpackage

FILE: design/color_switch_key_replace.sv
// Top level of the color switch: key, replace or extract pixels by a color table.
//
//   channel   direction   handshake                      payload
//   input     in          in_valid_i / in_stall_o        req_type_i .. frame_last_i
//   output    out         out_valid_o / out_stall_i      out_rgb_o .. frame_last_out_o
//   config    in          cfg_we_i                       cfg_idx_i, cfg_data_i
//
// Four register stages: input, table compare, first-hit pick, color select and output.
// One item enters per cycle unless the output stalls.
// Table writes are applied in pipeline order, so a pixel sees exactly the writes before it.
// Reset disables all table entries and clears the configuration registers.
// The whole pipeline holds while a result waits at a stalled output.
`timescale 1ns / 1ps

module color_switch_key_replace import csk_pkg::*; #(
  parameter int NUM_ENTRIES = NumEntriesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                req_type_i,
  input  logic [IdxW-1:0]     entry_index_i,
  input  logic                entry_enable_i,
  input  logic [RgbW-1:0]     color_rgb_i,
  input  logic [AlphaW-1:0]   pixel_alpha_i,
  input  logic [RgbW-1:0]     replacement_rgb_i,
  input  logic                frame_last_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [RgbW-1:0]     out_rgb_o,
  output logic [AlphaW-1:0]   out_alpha_o,
  output logic                hit_o,
  output logic [IdxW-1:0]     hit_index_o,
  output logic                frame_last_out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int SelW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  logic              enable_all_q;
  logic [ModeW-1:0]  switch_mode_q;
  logic [CountW-1:0] active_count_q;

  logic advance;

  // Stage 1: input register.
  logic              s1_vld_q, s1_req_q, s1_ena_q, s1_last_q;
  logic [IdxW-1:0]   s1_idx_q;
  logic [RgbW-1:0]   s1_rgb_q, s1_repl_q;
  logic [AlphaW-1:0] s1_alpha_q;

  // Stage 2: match vector.
  logic              s2_vld_q, s2_wr_q, s2_last_q;
  logic [IdxW-1:0]   s2_idx_q;
  logic [RgbW-1:0]   s2_rgb_q, s2_repl_q;
  logic [AlphaW-1:0] s2_alpha_q;
  logic [NUM_ENTRIES-1:0] s2_match;

  // Stage 3: first hit.
  logic              s3_vld_q, s3_wr_q, s3_last_q, s3_hit_q;
  logic [IdxW-1:0]   s3_idx_q, s3_hidx_q;
  logic [RgbW-1:0]   s3_rgb_q, s3_repl_q;
  logic [AlphaW-1:0] s3_alpha_q;
  logic [NUM_ENTRIES-1:0] s3_onehot_q;

  logic [NUM_ENTRIES-1:0] first_d;
  logic [IdxW-1:0]        hidx_d;
  logic [NUM_ENTRIES-1:0] act_mask;
  tbl_wr_t                match_wr;

  logic [RgbW-1:0] new_color_q [NUM_ENTRIES];
  logic [RgbW-1:0] sel_color;
  logic            nc_wr_ok;
  logic [SelW-1:0] nc_sel;

  logic              out_vld_q, out_hit_q, out_last_q;
  logic [RgbW-1:0]   out_rgb_q, out_rgb_d;
  logic [AlphaW-1:0] out_alpha_q, out_alpha_d;
  logic [IdxW-1:0]   out_hidx_q;

  assign advance    = !(out_vld_q && out_stall_i);
  assign in_stall_o = !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_all_q   <= 1'b0;
      switch_mode_q  <= MODE_REPLACE;
      active_count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENABLE_ALL:   enable_all_q   <= cfg_data_i[0];
        CFG_SWITCH_MODE:  switch_mode_q  <= cfg_data_i[ModeW-1:0];
        CFG_ACTIVE_COUNT: active_count_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      s1_vld_q  <= in_valid_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      out_vld_q <= s3_vld_q && !s3_wr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (in_valid_i) begin
        s1_req_q   <= req_type_i;
        s1_idx_q   <= entry_index_i;
        s1_ena_q   <= entry_enable_i;
        s1_rgb_q   <= color_rgb_i;
        s1_alpha_q <= pixel_alpha_i;
        s1_repl_q  <= replacement_rgb_i;
        s1_last_q  <= frame_last_i;
      end
      s2_wr_q     <= s1_req_q == REQ_WRITE;
      s2_idx_q    <= s1_idx_q;
      s2_repl_q   <= s1_repl_q;
      s2_rgb_q    <= s1_rgb_q;
      s2_alpha_q  <= s1_alpha_q;
      s2_last_q   <= s1_last_q;
      s3_wr_q     <= s2_wr_q;
      s3_idx_q    <= s2_idx_q;
      s3_repl_q   <= s2_repl_q;
      s3_rgb_q    <= s2_rgb_q;
      s3_alpha_q  <= s2_alpha_q;
      s3_last_q   <= s2_last_q;
      s3_hit_q    <= |s2_match;
      s3_onehot_q <= first_d;
      s3_hidx_q   <= hidx_d;
      out_rgb_q   <= out_rgb_d;
      out_alpha_q <= out_alpha_d;
      out_hit_q   <= s3_hit_q;
      out_hidx_q  <= s3_hidx_q;
      out_last_q  <= s3_last_q;
    end
  end

  // Entries at or beyond the active count take no part; with the master enable off none do.
  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      act_mask[i] = enable_all_q && (i < int'(active_count_q));
    end
  end

  always_comb begin
    match_wr.en  = s1_vld_q && (s1_req_q == REQ_WRITE);
    match_wr.idx = s1_idx_q;
    match_wr.ena = s1_ena_q;
    match_wr.rgb = s1_rgb_q;
  end

  csk_match #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_match (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .wr_i       (match_wr),
    .pix_rgb_i  (s1_rgb_q),
    .act_mask_i (act_mask),
    .match_o    (s2_match)
  );

  // Isolate the lowest set bit, then encode it.
  assign first_d = s2_match & (~s2_match + NUM_ENTRIES'(1));

  always_comb begin
    hidx_d = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (first_d[i]) begin
        hidx_d = hidx_d | IdxW'(i);
      end
    end
  end

  // Replacement colors are written at this stage so that pixels read them in order.
  assign nc_wr_ok = advance && s3_vld_q && s3_wr_q && (int'(s3_idx_q) < NUM_ENTRIES);
  assign nc_sel   = SelW'(s3_idx_q);

  always_ff @(posedge clk_i) begin
    if (nc_wr_ok) begin
      new_color_q[nc_sel] <= s3_repl_q;
    end
  end

  always_comb begin
    sel_color = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      sel_color = sel_color | (new_color_q[i] & {RgbW{s3_onehot_q[i]}});
    end
  end

  always_comb begin
    out_rgb_d   = s3_rgb_q;
    out_alpha_d = s3_alpha_q;
    if (enable_all_q) begin
      case (switch_mode_q)
        MODE_REPLACE: begin
          if (s3_hit_q) out_rgb_d = sel_color;
        end
        MODE_KEY: begin
          if (s3_hit_q) out_alpha_d = '0;
        end
        MODE_EXTRACT: begin
          if (!s3_hit_q) out_alpha_d = '0;
        end
        MODE_PASS: ;
        default: ;
      endcase
    end
  end

  assign out_valid_o      = out_vld_q;
  assign out_rgb_o        = out_rgb_q;
  assign out_alpha_o      = out_alpha_q;
  assign hit_o            = out_hit_q;
  assign hit_index_o      = out_hidx_q;
  assign frame_last_out_o = out_last_q;

endmodule

FILE: design/csk_match.sv
// Match table (enable bits and match colors) with the parallel compare stage.
`timescale 1ns / 1ps

module csk_match import csk_pkg::*; #(
  parameter int NUM_ENTRIES = NumEntriesDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  tbl_wr_t                wr_i,
  input  logic [RgbW-1:0]        pix_rgb_i,
  input  logic [NUM_ENTRIES-1:0] act_mask_i,
  output logic [NUM_ENTRIES-1:0] match_o
);

  localparam int SelW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  logic [NUM_ENTRIES-1:0] valid_q;
  logic [RgbW-1:0]        match_rgb_q [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] match_d, match_q;
  logic                   wr_ok;
  logic [SelW-1:0]        wsel;

  assign wr_ok = en_i && wr_i.en && (int'(wr_i.idx) < NUM_ENTRIES);
  assign wsel  = SelW'(wr_i.idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_ok) begin
      valid_q[wsel] <= wr_i.ena;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      match_rgb_q[wsel] <= wr_i.rgb;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      match_d[i] = act_mask_i[i] && valid_q[i] && (match_rgb_q[i] == pix_rgb_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= '0;
    end else if (en_i) begin
      match_q <= match_d;
    end
  end

  assign match_o = match_q;

endmodule
